// ----- design/connect_flood_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the connect flood filter
// Clocked property wrappers with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef CONNECT_FLOOD_FILTER_ASSERT_SVH
`define CONNECT_FLOOD_FILTER_ASSERT_SVH

// check a property while out of reset
`define CFF_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property at every edge, reset included
`define CFF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cff_pkg.sv -----
// ----------------------------------------------------------------------------
// cff_pkg
// Types, constants and helper functions of the connect flood filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cff_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int COUNT_W       = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ADDR_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int LIMIT_W       = 10;
  localparam int CLOSED_W      = 16;

  localparam logic [BYTE_W-1:0]   CONNECT_BYTE    = 8'h3C;
  localparam logic [BYTE_W-1:0]   DISCONNECT_BYTE = 8'h3E;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 10'd10;
  localparam logic [CLOSED_W-1:0] CLOSED_MAX      = 16'hFFFF;

  localparam int WARN_PERIOD = 50;
  localparam int REM_W       = $clog2(WARN_PERIOD);

  localparam int CMP_W        = ((COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W) + 1;
  localparam int DIGIT_W      = 4;
  localparam int DIGITS       = (CMP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int REM_IN_W     = DIGITS * DIGIT_W;
  localparam int DIGIT_CNT_W  = $clog2(DIGITS + 1);
  localparam int CLOSED_EXT_W = (COUNT_W > CLOSED_W) ? COUNT_W : CLOSED_W;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [BYTE_W-1:0] first_byte;
  } cff_in_t;

  typedef struct packed {
    logic                accept;
    logic                flood_warning;
    logic                closed_valid;
    logic [CLOSED_W-1:0] closed_count;
    logic                not_tracked;
  } cff_out_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic               vld;
    logic [ADDR_W-1:0]  addr;
    logic               conn;
    logic               disc;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               has_free;
    logic [IDX_W-1:0]   free_idx;
  } cff_tok_t;

  // insert broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } cff_ins_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MOD,
    ST_OUT
  } cff_state_e;

  // one binary long-division step of the remainder by WARN_PERIOD
  function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r, input logic b);
    logic [REM_W:0] t;
    t = {r, b};
    if (t >= (REM_W+1)'(WARN_PERIOD)) begin
      t = t - (REM_W+1)'(WARN_PERIOD);
    end
    return REM_W'(t);
  endfunction

  function automatic logic [CLOSED_W-1:0] sat_closed(input logic [COUNT_W-1:0] c);
    logic [CLOSED_EXT_W-1:0] ext;
    ext = CLOSED_EXT_W'(c);
    if (ext > CLOSED_EXT_W'(CLOSED_MAX)) begin
      return CLOSED_MAX;
    end
    return CLOSED_W'(ext);
  endfunction

endpackage

`default_nettype wire

// ----- design/cff_cell.sv -----
// ----------------------------------------------------------------------------
// cff_cell
// One source table entry; checks the passing search token and applies
// updates, then hands the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cff_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [cff_pkg::IDX_W-1:0]      idx_i,
  input  cff_pkg::cff_tok_t              tok_i,
  input  cff_pkg::cff_ins_t              ins_i,
  output cff_pkg::cff_tok_t              tok_o
);
  import cff_pkg::*;

  logic               valid_q, valid_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [COUNT_W-1:0] count_q, count_d;
  cff_tok_t           tok_q, tok_d;
  logic               hit;

  always_comb begin
    hit     = tok_i.vld && valid_q && (addr_q == tok_i.addr);
    tok_d   = tok_i;
    valid_d = valid_q;
    addr_d  = addr_q;
    count_d = count_q;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.count = count_q;
      if (tok_i.disc) begin
        valid_d = 1'b0;
      end else if (tok_i.conn && (count_q != '1)) begin
        count_d = count_q + COUNT_W'(1);
      end
    end
    if (tok_i.vld && !valid_q && !tok_i.has_free) begin
      tok_d.has_free = 1'b1;
      tok_d.free_idx = idx_i;
    end
    if (ins_i.en && (ins_i.idx == idx_i)) begin
      valid_d = 1'b1;
      addr_d  = ins_i.addr;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    count_q <= count_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ----- design/cff_rem.sv -----
// ----------------------------------------------------------------------------
// cff_rem
// Digit-serial remainder by the warning period; reports a zero remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module cff_rem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [cff_pkg::REM_IN_W-1:0]     value_i,
  output logic                             done_o,
  output logic                             zero_o
);
  import cff_pkg::*;

  logic                   busy_q, busy_d;
  logic [DIGIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_IN_W-1:0]    val_q, val_d;
  logic [REM_W-1:0]       rem_q, rem_d, rem_n;
  logic                   last;

  always_comb begin
    rem_n = rem_q;
    for (int k = 0; k < DIGIT_W; k++) begin
      rem_n = rem_step(rem_n, val_q[REM_IN_W-1-k]);
    end
  end

  assign last   = busy_q && (cnt_q == DIGIT_CNT_W'(1));
  assign done_o = last;
  assign zero_o = (rem_n == '0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIGIT_CNT_W'(DIGITS);
      val_d  = value_i;
      rem_d  = '0;
    end else if (busy_q) begin
      val_d = val_q << DIGIT_W;
      rem_d = rem_n;
      cnt_d = cnt_q - DIGIT_CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

endmodule

`default_nettype wire

// ----- design/connect_flood_filter.sv -----
// ----------------------------------------------------------------------------
// connect_flood_filter
// Per-source connect flood filter over a chain of table cells.
//
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one packet per
// transaction: source address and first byte. Output channel
// (out_valid_o/out_ready_i, out_data_o) returns one verdict per packet.
// cfg_we_i/cfg_wdata_i write the flood limit.
// One packet is in work at a time. A search token walks the TABLE_ENTRIES
// cells, one cell per cycle. A tracked connect above the limit then takes
// a digit-serial remainder by 50 for the flood warning. The verdict is
// registered in a result register, then copied into the output register
// in the output state.
// Reset empties the table and sets the limit to 10.
// A stalled receiver keeps its verdict in the output register; the next
// packet is still taken and worked, then waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module connect_flood_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cff_pkg::cff_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cff_pkg::cff_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [cff_pkg::LIMIT_W-1:0]   cfg_wdata_i
);
  import cff_pkg::*;

  cff_state_e         state_q, state_d;
  logic [LIMIT_W-1:0] limit_q;
  cff_out_t           res_q, res_d, res_c;
  cff_out_t           out_q;
  logic               out_valid_q, out_valid_d;

  cff_tok_t           tok [TABLE_ENTRIES+1];
  cff_tok_t           tail;
  cff_ins_t           ins;

  logic               launch, res_load, out_load, rem_start;
  logic               rem_done, rem_zero;
  logic               adv, over, need_mod;
  logic [CMP_W-1:0]   cnt_new, lim_ext, diff;

  // launch token
  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = launch;
    tok[0].addr     = in_data_i.source_address;
    tok[0].conn     = (in_data_i.first_byte == CONNECT_BYTE);
    tok[0].disc     = (in_data_i.first_byte == DISCONNECT_BYTE);
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cff_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .tok_i  (tok[g]),
      .ins_i  (ins),
      .tok_o  (tok[g+1])
    );
  end

  assign tail = tok[TABLE_ENTRIES];

  // verdict from the returning token
  always_comb begin
    adv      = (tail.count != '1);
    cnt_new  = adv ? (CMP_W'(tail.count) + CMP_W'(1)) : CMP_W'(tail.count);
    lim_ext  = CMP_W'(limit_q);
    over     = (cnt_new > lim_ext);
    diff     = cnt_new - lim_ext;
    need_mod = tail.conn && tail.found && adv && over;

    res_c               = '0;
    res_c.accept        = 1'b1;
    if (tail.disc && tail.found) begin
      res_c.closed_valid = 1'b1;
      res_c.closed_count = sat_closed(tail.count);
    end else if (tail.conn) begin
      if (tail.found) begin
        res_c.accept = !over;
      end else begin
        res_c.not_tracked = !tail.has_free;
      end
    end
  end

  cff_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .value_i (REM_IN_W'(diff)),
    .done_o  (rem_done),
    .zero_o  (rem_zero)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.vld) begin
          state_d = need_mod ? ST_MOD : ST_OUT;
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    res_load   = 1'b0;
    rem_start  = 1'b0;
    out_load   = 1'b0;
    ins        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SEARCH: begin
        res_load  = tail.vld;
        rem_start = tail.vld && need_mod;
        ins.en    = tail.vld && tail.conn && !tail.found && tail.has_free;
        ins.idx   = tail.free_idx;
        ins.addr  = tail.addr;
      end
      ST_MOD: begin
      end
      ST_OUT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  assign launch = in_valid_i && in_ready_o;

  always_comb begin
    res_d = res_q;
    if (res_load) begin
      res_d = res_c;
    end else if ((state_q == ST_MOD) && rem_done) begin
      res_d.flood_warning = rem_zero;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- design/cff_checker.sv -----
// ----------------------------------------------------------------------------
// cff_checker
// Port-level checks of the connect flood filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "connect_flood_filter_assert.svh"

module cff_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input cff_pkg::cff_out_t             out_data_o
);
  import cff_pkg::*;

  `CFF_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid_o,
                     "output valid in reset")

  `CFF_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o,
              "second transaction taken during search")

  `CFF_ASSERT(a_out_hold, clk_i, rst_ni,
              (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)),
              "stalled output changed")

  `CFF_ASSERT(a_close_passes, clk_i, rst_ni,
              (out_valid_o && out_data_o.closed_valid) |->
              (out_data_o.accept && !out_data_o.flood_warning && !out_data_o.not_tracked),
              "disconnect verdict inconsistent")

  `CFF_ASSERT(a_warn_drops, clk_i, rst_ni,
              (out_valid_o && (out_data_o.flood_warning || !out_data_o.accept)) |->
              (!out_data_o.not_tracked && !out_data_o.closed_valid &&
               (out_data_o.closed_count == '0) && !out_data_o.accept),
              "flood verdict inconsistent")

endmodule

bind connect_flood_filter cff_checker u_cff_checker (.*);

`default_nettype wire
